// File: design/cll_pkg.sv
package cll_pkg;

    // Default number of list nodes.
    localparam int NODE_COUNT_DEF = 8;

    // Request kinds.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    // Response status codes.
    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_REMOVED   = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;
    localparam logic [2:0] STAT_ELEMENT   = 3'd5;

    // Request transaction payload.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } req_t;

    // Response transaction payload.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] element;
        logic       last;
    } rsp_t;

    // Contents of one cell of the chain.
    typedef struct packed {
        logic       occ;
        logic [7:0] val;
    } node_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CMD_HOLD     = 2'd0,
        CMD_PUSH     = 2'd1,
        CMD_ROTATE   = 2'd2,
        CMD_ROT_DROP = 2'd3
    } cell_cmd_t;

endpackage

// File: design/cll_cell.sv
module cll_cell
    import cll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  node_t     left_node,
    input  node_t     right_node,
    input  node_t     head_node,
    output node_t     node
);

    logic       occ_reg;
    logic       occ_next;
    logic [7:0] val_reg;
    logic [7:0] val_next;

    // A push takes the left neighbour's contents. A rotation moves the
    // occupied region one place towards the head; the last occupied cell
    // takes the head's byte, or turns empty when the head is dropped.
    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        unique case (cmd)
            CMD_PUSH:
            begin
                occ_next = left_node.occ;
                val_next = left_node.val;
            end
            CMD_ROTATE, CMD_ROT_DROP:
            begin
                if (occ_reg)
                begin
                    if (right_node.occ)
                    begin
                        val_next = right_node.val;
                    end
                    else
                    begin
                        val_next = head_node.val;
                        occ_next = (cmd == CMD_ROTATE);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Occupancy is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // The stored byte needs no reset.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign node = '{occ: occ_reg, val: val_reg};

endmodule

// File: design/cursor_list_with_free_list.sv
// Linked list of bytes held as a chain of cells, the head in cell 0 and the
// elements in list order behind it; free capacity is the run of empty cells
// at the end of the chain. An insert that finds room pushes its byte into
// the head cell when it is accepted. A delete or a list request walks the
// list by rotating the occupied cells through the head cell once, one cell
// per cycle; a list walk pauses on every step, and a delete on its final
// step, whenever the response register is still occupied and not emptied.
// An empty list, a full list or an unused kind finishes in the acceptance
// cycle. A new request is taken only between walks, and only while the
// response register is free or being emptied in the same cycle.
module cursor_list_with_free_list
    import cll_pkg::*;
#(
    parameter int NodeCount = NODE_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CntW = $clog2(NodeCount + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic [CntW-1:0] step_reg;
    logic [CntW-1:0] step_next;
    logic           found_reg;
    logic           found_next;
    logic           list_reg;
    logic           list_next;
    logic [7:0]     key_reg;
    logic [7:0]     key_next;
    logic           rsp_valid_reg;
    rsp_t           rsp_reg;
    rsp_t           rsp_next;
    logic           rsp_load;
    logic           slot_free;
    logic           last_step;
    logic           hit;
    cell_cmd_t      cmd;

    node_t cell_q  [NodeCount];
    node_t left_in [NodeCount];
    node_t right_in[NodeCount];

    // The chain of cells with its neighbour connections.
    for (genvar i = 0; i < NodeCount; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = '{occ: 1'b1, val: req.value};
        end
        else
        begin : g_inner_left
            assign left_in[i] = cell_q[i-1];
        end

        if (i == NodeCount - 1)
        begin : g_end
            assign right_in[i] = '{occ: 1'b0, val: 8'h00};
        end
        else
        begin : g_inner_right
            assign right_in[i] = cell_q[i+1];
        end

        cll_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_node  (left_in[i]),
            .right_node (right_in[i]),
            .head_node  (cell_q[0]),
            .node       (cell_q[i])
        );
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign last_step = (step_reg == (count_reg - 1'b1));
    assign hit       = !found_reg && (cell_q[0].val == key_reg);

    // Request decode and walk sequencing.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        found_next = found_reg;
        list_next  = list_reg;
        key_next   = key_reg;
        cmd        = CMD_HOLD;
        rsp_load   = 1'b0;
        rsp_next   = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = slot_free;
                if (req_valid && slot_free)
                begin
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            rsp_load      = 1'b1;
                            rsp_next.last = 1'b1;
                            if (cell_q[NodeCount-1].occ)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                cmd             = CMD_PUSH;
                                count_next      = count_reg + 1'b1;
                                rsp_next.status = STAT_INSERTED;
                            end
                        end
                        KIND_DELETE, KIND_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_load        = 1'b1;
                                rsp_next.last   = 1'b1;
                                rsp_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                                step_next  = '0;
                                found_next = 1'b0;
                                list_next  = (req.kind == KIND_LIST);
                                key_next   = req.value;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (list_reg)
                begin
                    // Emit the head element, then rotate the next one in.
                    if (slot_free)
                    begin
                        cmd              = CMD_ROTATE;
                        rsp_load         = 1'b1;
                        rsp_next.status  = STAT_ELEMENT;
                        rsp_next.element = cell_q[0].val;
                        rsp_next.last    = last_step;
                        step_next        = step_reg + 1'b1;
                        if (last_step)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    // Compare the head; the first match is dropped.
                    if (!last_step || slot_free)
                    begin
                        cmd        = hit ? CMD_ROT_DROP : CMD_ROTATE;
                        found_next = found_reg || hit;
                        step_next  = step_reg + 1'b1;
                        if (last_step)
                        begin
                            rsp_load        = 1'b1;
                            rsp_next.last   = 1'b1;
                            rsp_next.status = (found_reg || hit) ? STAT_REMOVED
                                                                 : STAT_NOT_FOUND;
                            count_next      = count_reg - {{(CntW-1){1'b0}},
                                                           (found_reg || hit)};
                            state_next      = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            list_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            list_reg  <= list_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: design/cll_checker.sv
module cll_checker
    import cll_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A pending response stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response withdrawn before its transaction completed");

    // Only listed elements carry a byte.
    a_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STAT_ELEMENT) |-> (rsp.element == 8'h00))
        else $error("element byte set on a non-element response");

    // Every status other than a listed element is the sole response.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STAT_ELEMENT) |-> rsp.last)
        else $error("single response not marked last");

    // An insert answers in the following cycle.
    a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.kind == KIND_INSERT) |=>
        rsp_valid && ((rsp.status == STAT_INSERTED) || (rsp.status == STAT_FULL)))
        else $error("insert did not answer with inserted or full");

    // No request is taken while a walk is under way: a listed element
    // that is not the last is followed by more of the same walk.
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_ELEMENT) && !rsp.last |-> !req_ready)
        else $error("request accepted in the middle of a list walk");

endmodule

bind cursor_list_with_free_list cll_checker u_cll_checker (.*);
